// File: rtl/gcc_pkg.sv
// Shared constants, control structs and reset values for the greedy coin changer.
`timescale 1ns / 1ps
`default_nettype none

package gcc_pkg;

    localparam int NUM_DENOMS  = 6;
    localparam int AMOUNT_BITS = 16;
    localparam int VAL_W       = 16;
    localparam int SLOT_W      = 3;
    localparam int CNT_W       = $clog2(AMOUNT_BITS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COIN_COUNT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_0 = CFG_IDX_W'(1);

    localparam logic [SLOT_W-1:0] COIN_COUNT_RESET = SLOT_W'(6);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic div_init;
        logic div_step;
        logic emit;
    } gcc_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic div_last;
        logic slot_zero;
        logic out_free;
    } gcc_status_t;

    function automatic logic [VAL_W-1:0] coin_reset_value(input logic [SLOT_W-1:0] slot);
        logic [VAL_W-1:0] v;
        unique case (slot)
            SLOT_W'(0): v = VAL_W'(1);
            SLOT_W'(1): v = VAL_W'(2);
            SLOT_W'(2): v = VAL_W'(5);
            SLOT_W'(3): v = VAL_W'(10);
            SLOT_W'(4): v = VAL_W'(20);
            SLOT_W'(5): v = VAL_W'(50);
            default:    v = VAL_W'(100);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gcc_in_if.sv
// Request channel interface: one amount per request.
`timescale 1ns / 1ps
`default_nettype none

interface gcc_in_if
    import gcc_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [AMOUNT_BITS-1:0] amount;

    modport source (output valid, output amount, input ready);
    modport sink   (input valid, input amount, output ready);
endinterface

`default_nettype wire

// File: rtl/gcc_out_if.sv
// Result channel interface: one coin count per denomination slot.
`timescale 1ns / 1ps
`default_nettype none

interface gcc_out_if
    import gcc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] coin_slot;
    logic [VAL_W-1:0]  coins_of_slot;
    logic              last_item;
    logic              no_solution;
    logic [VAL_W-1:0]  leftover;
    logic [VAL_W-1:0]  total_coins;

    modport source (output valid, output coin_slot, output coins_of_slot, output last_item,
                    output no_solution, output leftover, output total_coins, input ready);
    modport sink   (input valid, input coin_slot, input coins_of_slot, input last_item,
                    input no_solution, input leftover, input total_coins, output ready);
endinterface

`default_nettype wire

// File: rtl/gcc_ctrl.sv
// Controller state machine that sequences the per-slot divisions.
`timescale 1ns / 1ps
`default_nettype none

module gcc_ctrl
    import gcc_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         req_valid,
    output logic        req_ready,
    input  gcc_status_t status,
    output gcc_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        req_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Wait until the output register can take the next result.
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.slot_zero ? ST_IDLE : ST_SETUP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gcc_datapath.sv
// Datapath: configuration registers, radix-2 divider, running totals and result register.
`timescale 1ns / 1ps
`default_nettype none

module gcc_datapath
    import gcc_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data,
    input  wire [AMOUNT_BITS-1:0]  amount,
    input  gcc_cmd_t               cmd,
    output gcc_status_t            status,
    gcc_out_if.source              rsp
);

    logic [SLOT_W-1:0]      coin_count_reg;
    logic [VAL_W-1:0]       coin_value_reg [0:NUM_DENOMS-1];

    logic [AMOUNT_BITS-1:0] money_reg;
    logic [VAL_W-1:0]       total_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [VAL_W-1:0]       div_reg;
    logic [AMOUNT_BITS-1:0] quot_reg;
    logic [VAL_W-1:0]       rem_reg;
    logic [CNT_W-1:0]       count_reg;

    logic                   out_valid_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [VAL_W-1:0]       out_coins_reg;
    logic                   out_last_reg;
    logic                   out_nosol_reg;
    logic [VAL_W-1:0]       out_left_reg;
    logic [VAL_W-1:0]       out_total_reg;

    logic [SLOT_W-1:0]      top_slot;
    logic [SLOT_W-1:0]      cfg_slot;
    logic [VAL_W:0]         shifted;
    logic [VAL_W+1:0]       diff;
    logic                   fits;
    logic                   div_zero;
    logic [VAL_W-1:0]       quot_now;
    logic [AMOUNT_BITS-1:0] money_now;
    logic [VAL_W-1:0]       total_now;
    logic                   is_last;

    // Highest slot in use: a zero count acts as one slot, a large count saturates.
    always_comb
    begin
        priority if (coin_count_reg == SLOT_W'(0))
        begin
            top_slot = SLOT_W'(0);
        end
        else if (coin_count_reg > SLOT_W'(NUM_DENOMS))
        begin
            top_slot = SLOT_W'(NUM_DENOMS - 1);
        end
        else
        begin
            top_slot = coin_count_reg - SLOT_W'(1);
        end
    end

    assign cfg_slot = SLOT_W'(cfg_index - CFG_COIN_VALUE_0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coin_count_reg <= COIN_COUNT_RESET;
            for (int i = 0; i < NUM_DENOMS; i++)
            begin
                coin_value_reg[i] <= coin_reset_value(SLOT_W'(i));
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_COIN_COUNT)
            begin
                coin_count_reg <= cfg_data[SLOT_W-1:0];
            end
            else if (cfg_index <= CFG_IDX_W'(NUM_DENOMS))
            begin
                coin_value_reg[cfg_slot] <= cfg_data[VAL_W-1:0];
            end
        end
    end

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign shifted = {rem_reg, quot_reg[AMOUNT_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};
    assign fits    = ~diff[VAL_W+1];

    // A zero denomination gives no coins and passes the remainder on unchanged.
    assign div_zero  = (div_reg == '0);
    assign quot_now  = div_zero ? '0 : VAL_W'(quot_reg);
    assign money_now = div_zero ? money_reg : AMOUNT_BITS'(rem_reg);
    assign total_now = total_reg + quot_now;
    assign is_last   = (slot_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            money_reg <= amount;
            total_reg <= '0;
            slot_reg  <= top_slot;
        end
        if (cmd.div_init)
        begin
            div_reg   <= coin_value_reg[slot_reg];
            quot_reg  <= money_reg;
            rem_reg   <= '0;
            count_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg   <= fits ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
            quot_reg  <= {quot_reg[AMOUNT_BITS-2:0], fits};
            count_reg <= count_reg + CNT_W'(1);
        end
        if (cmd.emit)
        begin
            money_reg     <= money_now;
            total_reg     <= total_now;
            slot_reg      <= slot_reg - SLOT_W'(1);
            out_slot_reg  <= slot_reg;
            out_coins_reg <= quot_now;
            out_last_reg  <= is_last;
            out_nosol_reg <= is_last && (money_now != '0);
            out_left_reg  <= is_last ? VAL_W'(money_now) : '0;
            out_total_reg <= is_last ? total_now : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.div_last  = (count_reg == CNT_W'(AMOUNT_BITS - 1));
    assign status.slot_zero = is_last;
    assign status.out_free  = ~out_valid_reg | rsp.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.coin_slot     = out_slot_reg;
    assign rsp.coins_of_slot = out_coins_reg;
    assign rsp.last_item     = out_last_reg;
    assign rsp.no_solution   = out_nosol_reg;
    assign rsp.leftover      = out_left_reg;
    assign rsp.total_coins   = out_total_reg;

endmodule

`default_nettype wire

// File: rtl/greedy_coin_change.sv
// Top level of the greedy coin changer: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Each request carries an amount, which the block splits greedily over the
// configured coin denominations, working from the highest slot in use down to
// slot 0. It returns one result per slot in use, highest slot first; the
// result for slot 0 is marked last and also carries the total coin count, the
// leftover amount and a no-solution flag that is set when the leftover is
// nonzero. One request is handled at a time. For each slot the block fetches
// the denomination, runs the radix-2 restoring divider and writes the result
// register. The output register lets the divider work on the next slot while
// a result still waits to be taken. Configuration writes go through a plain
// write port: index 0 is the number of slots in use (zero acts as one, values
// above six act as six), indexes 1 to 6 are the denominations of slots 0 to 5,
// and index 7 is ignored. A zero denomination gives no coins and passes the
// remainder on. Write the configuration only while the block is idle.
module greedy_coin_change
    import gcc_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data,
    gcc_in_if.sink               req,
    gcc_out_if.source            rsp
);

    gcc_cmd_t    cmd;
    gcc_status_t status;
    logic        req_ready;

    assign req.ready = req_ready;

    // The controller takes a new request only when idle and steps the
    // datapath through setup, division and result write for every slot.
    gcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the divider and the result register.
    gcc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .amount    (req.amount),
        .cmd       (cmd),
        .status    (status),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: tb/gcc_checker.sv
// Scoreboard for the greedy coin changer: mirrors the registers, predicts and compares results.
`timescale 1ns / 1ps

module gcc_checker
    import gcc_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data,
    gcc_in_if                    req,
    gcc_out_if                   rsp,
    output int                   fail_count,
    output int                   results_due
);

    localparam logic [VAL_W-1:0] DENOM_AT_RESET [NUM_DENOMS] =
        '{VAL_W'(1), VAL_W'(2), VAL_W'(5), VAL_W'(10), VAL_W'(20), VAL_W'(50)};

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  coins;
        logic              last;
        logic              no_sol;
        logic [VAL_W-1:0]  leftover;
        logic [VAL_W-1:0]  total;
    } coin_result_t;

    logic [SLOT_W-1:0] slots_in_use;
    logic [VAL_W-1:0]  denom [NUM_DENOMS];
    coin_result_t      change_due [$];

    // Register mirror, updated at the same edge as the block's own registers.
    always @(posedge clk or negedge rst_n)
    begin : mirror_regs
        int slot_idx;
        if (!rst_n)
        begin
            slots_in_use <= COIN_COUNT_RESET;
            denom        <= DENOM_AT_RESET;
        end
        else if (cfg_wr_en)
        begin
            slot_idx = int'(cfg_index) - int'(CFG_COIN_VALUE_0);
            if (cfg_index == CFG_COIN_COUNT)
                slots_in_use <= cfg_data[SLOT_W-1:0];
            else if (slot_idx >= 0 && slot_idx < NUM_DENOMS)
                denom[slot_idx] <= cfg_data[VAL_W-1:0];
        end
    end

    // Greedy split, highest slot in use first; a zero denomination gives no coins.
    function automatic void predict_change(input logic [AMOUNT_BITS-1:0] amount);
        int           used;
        int           s;
        logic [31:0]  rest;
        logic [31:0]  quot;
        logic [31:0]  total;
        coin_result_t r;
        used = int'(slots_in_use);
        if (used == 0)
            used = 1;
        if (used > NUM_DENOMS)
            used = NUM_DENOMS;
        rest  = 32'(amount);
        total = '0;
        for (s = used - 1; s >= 0; s--)
        begin
            quot = '0;
            if (denom[s] != '0)
            begin
                quot = rest / 32'(denom[s]);
                rest = rest - quot * 32'(denom[s]);
            end
            total   = total + quot;
            r       = '0;
            r.slot  = SLOT_W'(s);
            r.coins = quot[VAL_W-1:0];
            r.last  = (s == 0);
            if (s == 0)
            begin
                r.no_sol   = (rest != '0);
                r.leftover = rest[VAL_W-1:0];
                r.total    = total[VAL_W-1:0];
            end
            change_due.push_back(r);
        end
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : watch_channels
        coin_result_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                predict_change(req.amount);
            if (rsp.valid && rsp.ready)
            begin
                if (change_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual slot %0d coins %0d",
                             $time, rsp.coin_slot, rsp.coins_of_slot);
                end
                else
                begin
                    want = change_due.pop_front();
                    check_field("coin_slot", want.slot, rsp.coin_slot);
                    check_field("coins_of_slot", want.coins, rsp.coins_of_slot);
                    check_field("last_item", want.last, rsp.last_item);
                    check_field("no_solution", want.no_sol, rsp.no_solution);
                    check_field("leftover", want.leftover, rsp.leftover);
                    check_field("total_coins", want.total, rsp.total_coins);
                end
            end
            results_due = change_due.size();
        end
    end

endmodule

// File: tb/tb.sv
// Top of the greedy coin changer testbench: clock, reset, stimulus, result-side stalls and verdict.
`timescale 1ns / 1ps

module tb;
    import gcc_pkg::*;

    localparam int CLK_PERIOD      = 8;
    // Long result-side hold-off; it lets the block fill its output register and stall requests.
    localparam int HOLD_OFF_CYCLES = 300;
    // The tail wait covers one more six-slot request with margin.
    localparam int DRAIN_CYCLES    = 150;
    // Worst quiet stretch of a correct run is the hold-off plus one request plus the longest
    // gaps on both sides; the watchdog allows several times that.
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_REQUESTS  = 19;

    // Index 7 lies past the last denomination and is ignored by the block.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX =
        CFG_IDX_W'(int'(CFG_COIN_VALUE_0) + NUM_DENOMS);

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gcc_in_if  req ();
    gcc_out_if rsp ();

    int fail_count;
    int results_due;
    int quiet_cycles = 0;

    // Idle rates: per request on the request side, per cycle on the result side.
    int req_idle_pct = 0;
    int rsp_idle_pct = 0;
    bit hold_off_req = 1'b0;

    // Denominations that the next configuration phase writes, slot 0 first.
    logic [CFG_DATA_W-1:0] denom_plan [NUM_DENOMS];

    always #(CLK_PERIOD / 2) clk = ~clk;

    greedy_coin_change i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    gcc_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // The watchdog restarts whenever a request or a result is taken. A hang anywhere,
    // including a block that never drains, ends the run here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side. The ready line gets exactly one assignment per edge. A hold-off asked
    // for by the stimulus is counted down here, once; otherwise stalls come in random
    // bursts at the rate that the current phase sets.
    initial
    begin : result_side
        int stall_left;
        int hold_left;
        bit hold_seen;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 1'b0;
        rsp.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_seen)
            begin
                hold_seen = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (rsp_idle_pct > 0 && $urandom_range(1, 100) <= rsp_idle_pct)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // One register write per edge; the caller lowers the enable after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Writes the slot count and every denomination from denom_plan, then pokes the
    // unused index with junk to show that it lands nowhere. The count write carries
    // random upper bits, which the block must drop.
    task automatic program_coins(input logic [SLOT_W-1:0] count);
        logic [CFG_DATA_W-1:0] count_word;
        int                    s;
        count_word                = CFG_DATA_W'($urandom);
        count_word[SLOT_W-1:0]    = count;
        write_reg(CFG_COIN_COUNT, count_word);
        for (s = 0; s < NUM_DENOMS; s++)
            write_reg(CFG_COIN_VALUE_0 + CFG_IDX_W'(s), denom_plan[s]);
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one amount and returns at the edge where the block takes it, with valid
    // still high so that back-to-back requests need no extra assignment. Before the
    // request, a random gap may drop valid and put junk on the amount lines.
    task automatic send_amount(input logic [AMOUNT_BITS-1:0] amt);
        int gap;
        if (req_idle_pct > 0 && $urandom_range(1, 100) <= req_idle_pct)
        begin
            gap = $urandom_range(1, 19);
            req.valid  <= 1'b0;
            req.amount <= AMOUNT_BITS'($urandom);
            repeat (gap) @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.amount <= amt;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Closes a phase: no more requests, then wait until every predicted result is in.
    // Every request yields at least one result, so the block is idle once the count
    // reaches zero; a few spare cycles let its controller settle.
    task automatic finish_phase();
        req.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Amounts lean toward the ends of the range and toward small values, where the
    // interesting remainders sit; the rest are full 16-bit random values.
    function automatic logic [AMOUNT_BITS-1:0] pick_amount();
        logic [AMOUNT_BITS-1:0] amt;
        case ($urandom_range(0, 9))
            0:       amt = '0;
            1:       amt = '1;
            2, 3:    amt = AMOUNT_BITS'($urandom_range(0, 300));
            default: amt = AMOUNT_BITS'($urandom);
        endcase
        return amt;
    endfunction

    // A random configuration. Half of the time it is an ascending coin system built by
    // multiplying up from a small first coin, which gives many nonzero counts; the other
    // half is a free mix of zeros, all-ones, small and large random values in any order.
    task automatic plan_random_coins(output logic [SLOT_W-1:0] count);
        logic [31:0] coin;
        int          s;
        case ($urandom_range(0, 9))
            0:       count = SLOT_W'(0);
            1:       count = SLOT_W'(7);
            2:       count = SLOT_W'(1);
            default: count = SLOT_W'($urandom_range(2, NUM_DENOMS));
        endcase
        if ($urandom_range(0, 1) == 0)
        begin
            coin = $urandom_range(1, 3);
            for (s = 0; s < NUM_DENOMS; s++)
            begin
                denom_plan[s] = (coin > 32'hFFFF) ? '1 : CFG_DATA_W'(coin);
                coin = coin * $urandom_range(2, 5) + $urandom_range(0, 3);
            end
        end
        else
        begin
            for (s = 0; s < NUM_DENOMS; s++)
            begin
                case ($urandom_range(0, 7))
                    0:       denom_plan[s] = '0;
                    1:       denom_plan[s] = '1;
                    2, 3:    denom_plan[s] = CFG_DATA_W'($urandom_range(1, 30));
                    default: denom_plan[s] = CFG_DATA_W'($urandom);
                endcase
            end
        end
    endtask

    initial
    begin : stimulus
        logic [SLOT_W-1:0] count;
        int                phase;
        int                n;

        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        req.valid  = 1'b0;
        req.amount = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, with moderate idling on both sides.
        req_idle_pct = 25;
        rsp_idle_pct = 8;

        // Reset denominations 1, 2, 5, 10, 20, 50 with six slots: zero amount, the
        // largest amount, one of each coin (88), and values just under a coin.
        send_amount(AMOUNT_BITS'(0));
        send_amount('1);
        send_amount(AMOUNT_BITS'(88));
        send_amount(AMOUNT_BITS'(49));
        send_amount(AMOUNT_BITS'(3));
        finish_phase();

        // A slot count above six saturates to six. The coins include the largest
        // value, and slot 0 holds 3, so a leftover can remain and the no-solution flag rises.
        denom_plan = '{CFG_DATA_W'(3), CFG_DATA_W'(7), CFG_DATA_W'(100),
                       CFG_DATA_W'(1000), CFG_DATA_W'(30000), '1};
        program_coins(SLOT_W'(7));
        send_amount('1);
        send_amount(AMOUNT_BITS'(2));
        send_amount(AMOUNT_BITS'(65534));
        send_amount(AMOUNT_BITS'(31110));
        finish_phase();

        // A zero slot count acts as one slot; slot 0 holds the largest denomination.
        denom_plan = '{'1, '0, '0, '0, '0, '0};
        program_coins(SLOT_W'(0));
        send_amount('1);
        send_amount(AMOUNT_BITS'(65534));
        send_amount(AMOUNT_BITS'(0));
        finish_phase();

        // Denominations out of order, with zeros in slot 0 and slot 3: the pass still
        // visits every slot, and a zero slot gives nothing and passes the rest on.
        denom_plan = '{'0, CFG_DATA_W'(4), CFG_DATA_W'(7), '0, '1, CFG_DATA_W'(9)};
        program_coins(SLOT_W'(6));
        send_amount('1);
        send_amount(AMOUNT_BITS'(40));
        send_amount(AMOUNT_BITS'(0));
        send_amount(AMOUNT_BITS'(3));
        finish_phase();

        // A single slot in use, so every result is the last one.
        denom_plan = '{CFG_DATA_W'(4), CFG_DATA_W'(1), CFG_DATA_W'(1),
                       CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1)};
        program_coins(SLOT_W'(1));
        send_amount(AMOUNT_BITS'(9));
        send_amount('1);
        finish_phase();

        // Random part. Each phase gets a fresh configuration. Phase 1 runs without any
        // idling, phase 3 holds the result side off for a long stretch while requests
        // keep coming, and the last phase runs with no idling at all.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            plan_random_coins(count);
            program_coins(count);
            if (phase == 1 || phase == RANDOM_PHASES - 1)
            begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
            end
            else if (phase == 3)
            begin
                req_idle_pct = 0;
                rsp_idle_pct = 5;
                hold_off_req = 1'b1;
            end
            else
            begin
                req_idle_pct = $urandom_range(10, 40);
                rsp_idle_pct = $urandom_range(3, 15);
            end
            for (n = 0; n < PHASE_REQUESTS; n++)
                send_amount(pick_amount());
            finish_phase();
        end

        // Everything predicted has arrived; give the block time to show any stray result.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/gcc_pkg.sv
rtl/gcc_in_if.sv
rtl/gcc_out_if.sv
rtl/gcc_ctrl.sv
rtl/gcc_datapath.sv
rtl/greedy_coin_change.sv
tb/gcc_checker.sv
tb/tb.sv
